@@ rtl/substring_first_last_search_core_defines.svh @@
// Assertion macros for the substring search core.
// Used by the top level only; no other dependencies.
`ifndef SUBSTRING_FIRST_LAST_SEARCH_CORE_DEFINES_SVH
`define SUBSTRING_FIRST_LAST_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SFLS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfls assertion failed");
`define SFLS_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfls assertion failed");
`else
`define SFLS_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SFLS_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/sfls_pkg.sv @@
// Shared types and constants of the substring search core.
// No dependencies.
`default_nettype none
package sfls_pkg;

  localparam int unsigned NeedleBytes = 16;
  localparam int unsigned PosW        = 15;
  localparam int unsigned LenW        = 5;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEEDLE_LOW  = 8'd0,
    CFG_NEEDLE_HIGH = 8'd1,
    CFG_NEEDLE_LEN  = 8'd2,
    CFG_SEARCH_MODE = 8'd3
  } sfls_cfg_idx_e;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               first_of_string;
    logic               last_of_string;
    logic [PosW-1:0]    hay_length;
    logic signed [15:0] start_index;
  } sfls_in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_index;
  } sfls_out_t;

  // Live configuration seen by the scan logic.
  typedef struct packed {
    logic [LenW-1:0] length;
    logic            len_ok;
    logic            mode_last;
  } sfls_cfg_t;

endpackage
`default_nettype wire

@@ rtl/substring_first_last_search_core.sv @@
// Substring search core: first or last needle match in a streamed haystack.
// A result is offered from the result register after the final byte passes
//   the input register and is consumed.
// Throughput: one byte per cycle (combinational compare) unless a result stalls.
// Reset: asynchronous, active low; clears configuration, window and tracking
//   state. No clearing pass; the block takes bytes right after reset.
`default_nettype none
`include "substring_first_last_search_core_defines.svh"
module substring_first_last_search_core import sfls_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = 16,
  parameter int unsigned MAX_STRING = 32767
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Byte stream in
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sfls_in_t            in_data_i,
  // Result out
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sfls_out_t                out_data_o,
  // Configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  sfls_cfg_t             cfg_w;
  logic [7:0]            aligned_w [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] mask_w;
  logic                  hit_w;
  sfls_out_t             result_w;

  logic      in_vld_q;
  sfls_in_t  in_q;
  logic      out_vld_q, out_vld_d;
  sfls_out_t out_q;
  logic      out_blocked_w, consume_w, in_xfer_w;

  // The user must write configuration only while idle; unchecked, always taken.
  assign cfg_ready_o = 1'b1;

  sfls_cfg #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg_w),
    .aligned_o  (aligned_w),
    .mask_o     (mask_w)
  );

  // The held byte is consumed unless it ends a string and the result
  // register is still full and stalled. Bytes without a result never wait.
  assign out_blocked_w = out_vld_q && out_stall_i;
  assign consume_w     = in_vld_q && !(in_q.last_of_string && out_blocked_w);
  assign in_stall_o    = in_vld_q && !consume_w;
  assign in_xfer_w     = in_valid_i && !in_stall_o;

  // Input register: load on every transfer, drop the valid once consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer_w || consume_w) begin
      in_vld_q <= in_xfer_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer_w) begin
      in_q <= in_data_i;
    end
  end

  sfls_window #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (consume_w),
    .byte_i    (in_q.data_byte),
    .aligned_i (aligned_w),
    .mask_i    (mask_w),
    .hit_o     (hit_w)
  );

  sfls_scan #(
    .MAX_STRING (MAX_STRING)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume_w),
    .item_i   (in_q),
    .cfg_i    (cfg_w),
    .hit_i    (hit_w),
    .result_o (result_w)
  );

  // Result register: fill on a consumed final byte, empty on an output transfer.
  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (consume_w && in_q.last_of_string) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume_w && in_q.last_of_string) begin
      out_q <= result_w;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A new result only ever follows a consumed final byte.
  `SFLS_ASSERT_NXT(a_result_from_last, clk_i, rst_ni,
                   !out_vld_q && !(consume_w && in_q.last_of_string), !out_vld_q)
  // Input backs up only behind a stalled result with a final byte waiting.
  `SFLS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o,
                   in_vld_q && in_q.last_of_string && out_vld_q && out_stall_i)
  // A not-found result carries a zero index.
  `SFLS_ASSERT_IMP(a_miss_zero_index, clk_i, rst_ni, out_vld_q && !out_q.found,
                   out_q.match_index == '0)

endmodule
`default_nettype wire

@@ rtl/sfls_cfg.sv @@
// Configuration registers and the length-aligned needle image.
// Depends on sfls_pkg.
`default_nettype none
module sfls_cfg import sfls_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_index_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output sfls_cfg_t                cfg_o,
  output logic [7:0]               aligned_o [NEEDLE_MAX],
  output logic [NEEDLE_MAX-1:0]    mask_o
);

  logic [7:0]            needle_q [NeedleBytes];
  logic [LenW-1:0]       length_q;
  logic                  mode_q;
  logic [7:0]            aligned_w [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] mask_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NeedleBytes; j++) needle_q[j] <= 8'h00;
      length_q <= '0;
      mode_q   <= 1'b0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_NEEDLE_LOW: begin
          for (int j = 0; j < 8; j++) needle_q[j] <= wr_data_i[8*j +: 8];
        end
        CFG_NEEDLE_HIGH: begin
          for (int j = 0; j < 8; j++) needle_q[j+8] <= wr_data_i[8*j +: 8];
        end
        CFG_NEEDLE_LEN:  length_q <= wr_data_i[LenW-1:0];
        CFG_SEARCH_MODE: mode_q   <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  // Entry i of the window (age i) meets needle byte length-1-i.
  always_comb begin
    logic [LenW-1:0] k;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      k            = length_q - LenW'(1) - LenW'(i);
      aligned_w[i] = needle_q[k[3:0]];
      mask_w[i]    = LenW'(i) < length_q;
    end
  end

  assign aligned_o       = aligned_w;
  assign mask_o          = mask_w;
  assign cfg_o.length    = length_q;
  assign cfg_o.len_ok    = (length_q != '0) && (length_q <= LenW'(NEEDLE_MAX));
  assign cfg_o.mode_last = mode_q;

endmodule
`default_nettype wire

@@ rtl/sfls_window.sv @@
// Byte history and parallel compare of the newest window against the needle.
// Depends on sfls_pkg.
`default_nettype none
module sfls_window import sfls_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  shift_i,
  input  wire logic [7:0]            byte_i,
  input  wire logic [7:0]            aligned_i [NEEDLE_MAX],
  input  wire logic [NEEDLE_MAX-1:0] mask_i,
  output logic                       hit_o
);

  localparam int unsigned HistDepth = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

  logic [7:0]            hist_q [HistDepth];
  logic [7:0]            win_w  [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] ok_w;

  assign win_w[0] = byte_i;
  for (genvar i = 1; i < NEEDLE_MAX; i++) begin : g_win
    assign win_w[i] = hist_q[i-1];
  end

  // Advance the history on every consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < HistDepth; j++) hist_q[j] <= 8'h00;
    end else if (shift_i) begin
      hist_q[0] <= byte_i;
      for (int j = 1; j < HistDepth; j++) hist_q[j] <= hist_q[j-1];
    end
  end

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      ok_w[i] = !mask_i[i] || (win_w[i] == aligned_i[i]);
    end
  end

  assign hit_o = &ok_w;

endmodule
`default_nettype wire

@@ rtl/sfls_scan.sv @@
// Per-string tracking: start normalization, position count, best match.
// Depends on sfls_pkg.
`default_nettype none
module sfls_scan import sfls_pkg::*; #(
  parameter int unsigned MAX_STRING = 32767
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire sfls_in_t  item_i,
  input  wire sfls_cfg_t cfg_i,
  input  wire logic      hit_i,
  output sfls_out_t      result_o
);

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_STRING);

  logic [PosW-1:0] pos_q, pos_d, rstart_q, rstart_d, best_q, best_d, held_q, held_d;
  logic            sval_q, sval_d, have_q, have_d;
  logic signed [16:0] norm_w;
  logic            norm_ok_w;
  logic [PosW:0]   pos_inc_w;
  logic [PosW:0]   st_w;
  logic            take_w, found_w;

  // Start index: add the length when negative, keep when inside the string.
  assign norm_w    = 17'(item_i.start_index) +
                     (item_i.start_index[15] ? $signed({2'b00, item_i.hay_length})
                                             : 17'sd0);
  assign norm_ok_w = !norm_w[16] && (norm_w[15:0] < {1'b0, item_i.hay_length});

  always_comb begin
    if (item_i.first_of_string) begin
      pos_d    = '0;
      rstart_d = norm_ok_w ? norm_w[PosW-1:0] : '0;
      sval_d   = norm_ok_w;
      have_d   = 1'b0;
      best_d   = '0;
      held_d   = item_i.hay_length;
    end else begin
      pos_d    = pos_q;
      rstart_d = rstart_q;
      sval_d   = sval_q;
      have_d   = have_q;
      best_d   = best_q;
      held_d   = held_q;
    end
    pos_inc_w = {1'b0, pos_d} + (PosW+1)'(1);
    st_w      = pos_inc_w - (PosW+1)'(cfg_i.length);
    take_w    = 1'b0;
    if (pos_d < MaxPos) begin
      take_w = cfg_i.len_ok && sval_d && (pos_inc_w >= (PosW+1)'(cfg_i.length)) &&
               (st_w[PosW-1:0] >= rstart_d) && hit_i &&
               (cfg_i.mode_last || !have_d);
      pos_d  = pos_inc_w[PosW-1:0];
    end
    if (take_w) begin
      have_d = 1'b1;
      best_d = st_w[PosW-1:0];
    end
    found_w = have_d && sval_d && cfg_i.len_ok && ((PosW)'(cfg_i.length) <= held_d);
  end

  assign result_o.found       = found_w;
  assign result_o.match_index = found_w ? best_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rstart_q <= '0;
      sval_q   <= 1'b0;
      have_q   <= 1'b0;
      best_q   <= '0;
      held_q   <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      rstart_q <= rstart_d;
      sval_q   <= sval_d;
      have_q   <= have_d;
      best_q   <= best_d;
      held_q   <= held_d;
    end
  end

endmodule
`default_nettype wire
